### rtl/core/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

   localparam int DEPTH_DEFAULT       = 512;
   localparam int HANDLE_BITS_DEFAULT = 16;

   localparam int JOB_W  = 16;
   localparam int CODE_W = 2;
   localparam int OCC_W  = 10;

   // request codes
   localparam logic [CODE_W-1:0] REQ_PUSH  = 2'd0;
   localparam logic [CODE_W-1:0] REQ_POP   = 2'd1;
   localparam logic [CODE_W-1:0] REQ_STEAL = 2'd2;
   localparam logic [CODE_W-1:0] REQ_NOP   = 2'd3;

   // status codes
   localparam logic [CODE_W-1:0] ST_DONE  = 2'd0;
   localparam logic [CODE_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [CODE_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0] req_type;
      logic [JOB_W-1:0]  job_in;
   } wsd_req_type;

   typedef struct packed {
      logic [JOB_W-1:0]  job_out;
      logic [CODE_W-1:0] status;
      logic [OCC_W-1:0]  occupancy;
      logic              is_empty;
   } wsd_rsp_type;

endpackage

`default_nettype wire

### rtl/core/wsd_ram.sv
`default_nettype none

module wsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/work_stealing_deque_top.sv
// Work-stealing deque of job handles held in a ring buffer memory.
// Request channel (req_valid/req_ready/req_data): push a handle at the bottom,
// pop the newest handle from the bottom, or steal the oldest from the top.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, in request order, carrying the handle taken, a status (done, queue
// empty, full and push refused), the occupancy and an empty flag.
// Response path: the memory read completes at the accepting edge, the read
// stage holds it with its tags, and the output register that drives rsp_valid
// loads from the read stage when it is free or being drained.
// Throughput: one request per cycle while req_ready is high. The pointers
// update at acceptance and the memory has separate read and write ports, so a
// pop right after a push reads the freshly written slot without a stall.
// When rsp_ready is low, the response register and the read stage behind it
// hold; the request channel keeps accepting until both are occupied, then
// deasserts req_ready until the response is taken.
// Reset (synchronous, active high) empties the queue by zeroing both
// pointers; the slot memory itself is not cleared.
`default_nettype none

module work_stealing_deque_top
   import wsd_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire wsd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output wsd_rsp_type      rsp_data
);

   localparam int PTR_W  = $clog2(2 * DEPTH);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W:0]   PTR_SPAN  = (PTR_W + 1)'(2 * DEPTH);

   function automatic logic [PTR_W-1:0] held_of(input logic [PTR_W-1:0] b,
                                                 input logic [PTR_W-1:0] t);
      logic [PTR_W:0] diff;
      diff = {1'b0, b} - {1'b0, t};
      if (b < t) begin
         diff = diff + PTR_SPAN;
      end
      return diff[PTR_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
      return s[SLOT_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   logic [PTR_W-1:0] bottom_ptr_ff, bottom_ptr_in;
   logic [PTR_W-1:0] top_ptr_ff, top_ptr_in;

   logic              pend_valid_ff, pend_valid_in;
   logic              pend_take_ff, pend_take_in;
   logic [CODE_W-1:0] pend_status_ff, pend_status_in;
   logic [OCC_W-1:0]  pend_occ_ff, pend_occ_in;
   logic              pend_empty_ff, pend_empty_in;

   logic        out_valid_ff, out_valid_in;
   wsd_rsp_type out_data_ff, out_data_in;

   logic                   req_fire;
   logic                   pend_moves;
   logic [PTR_W-1:0]       held_now;
   logic [PTR_W-1:0]       held_next;
   logic                   is_full;
   logic                   is_none;
   logic                   wr_en;
   logic                   rd_en;
   logic [SLOT_W-1:0]      wr_addr;
   logic [SLOT_W-1:0]      rd_addr;
   logic [HANDLE_BITS-1:0] rd_data;

   assign held_now = held_of(bottom_ptr_ff, top_ptr_ff);
   assign is_full  = (held_now >= PTR_DEPTH);
   assign is_none  = (held_now == '0);

   // the read stage advances when the output register is free or being drained
   assign pend_moves = pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !pend_valid_ff || pend_moves;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      bottom_ptr_in  = bottom_ptr_ff;
      top_ptr_in     = top_ptr_ff;
      pend_take_in   = 1'b0;
      pend_status_in = ST_DONE;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      wr_addr        = slot_of(bottom_ptr_ff);
      rd_addr        = slot_of(bottom_ptr_ff);
      if (req_fire) begin
         case (req_data.req_type)
            REQ_PUSH: begin
               if (is_full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  bottom_ptr_in = ptr_inc(bottom_ptr_ff);
               end
            end
            REQ_POP: begin
               if (is_none) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  bottom_ptr_in = ptr_dec(bottom_ptr_ff);
                  rd_addr       = slot_of(bottom_ptr_in);
                  rd_en         = 1'b1;
                  pend_take_in  = 1'b1;
               end
            end
            REQ_STEAL: begin
               if (is_none) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  rd_addr      = slot_of(top_ptr_ff);
                  rd_en        = 1'b1;
                  pend_take_in = 1'b1;
                  top_ptr_in   = ptr_inc(top_ptr_ff);
               end
            end
            default: begin
               pend_status_in = ST_DONE;
            end
         endcase
      end
   end

   assign held_next     = held_of(bottom_ptr_in, top_ptr_in);
   assign pend_occ_in   = OCC_W'(held_next);
   assign pend_empty_in = (held_next == '0);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (pend_moves) begin
         pend_valid_in = 1'b0;
      end
      if (req_fire) begin
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (pend_moves) begin
         out_valid_in          = 1'b1;
         out_data_in.job_out   = pend_take_ff ? JOB_W'(rd_data) : '0;
         out_data_in.status    = pend_status_ff;
         out_data_in.occupancy = pend_occ_ff;
         out_data_in.is_empty  = pend_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ptr_ff <= '0;
         top_ptr_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         bottom_ptr_ff <= bottom_ptr_in;
         top_ptr_ff    <= top_ptr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // hold the read-stage tags while the stage waits
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_take_ff   <= pend_take_in;
         pend_status_ff <= pend_status_in;
         pend_occ_ff    <= pend_occ_in;
         pend_empty_ff  <= pend_empty_in;
      end
      out_data_ff <= out_data_in;
   end

   wsd_ram #(
      .WIDTH(HANDLE_BITS),
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(HANDLE_BITS'(req_data.job_in)),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_now <= PTR_DEPTH)
      else $error("deque occupancy exceeds its depth");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (pend_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request refused while a pipeline stage is free");

   a_push_moves_bottom: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.req_type == REQ_PUSH && !is_full)
      |=> (bottom_ptr_ff != $past(bottom_ptr_ff)))
      else $error("accepted push did not advance the bottom pointer");

   a_top_moves_on_steal: assert property (@(posedge clock) disable iff (reset)
      (top_ptr_ff != top_ptr_in)
      |-> (req_fire && req_data.req_type == REQ_STEAL && !is_none))
      else $error("top pointer moved without a successful steal");

endmodule

`default_nettype wire
